// ----- rtl/core/crfbs_pkg.sv -----
// ----------------------------------------------------------------------------
// crfbs_pkg
// Shared types and constants of the clipped rectangle fill byte sequencer.
// ----------------------------------------------------------------------------
package crfbs_pkg;

	localparam int COORD_W = 9;
	localparam int PANEL_W = 10;
	localparam int WORD_W  = 16;
	localparam int BYTE_W  = 8;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_PULL  = 1'b1;

	localparam logic [BYTE_W-1:0] OP_CASET = 8'h2A;
	localparam logic [BYTE_W-1:0] OP_RASET = 8'h2B;
	localparam logic [BYTE_W-1:0] OP_RAMWR = 8'h2C;

	localparam logic [PANEL_W-1:0] PANEL_W_RST = 10'd320;
	localparam logic [PANEL_W-1:0] PANEL_H_RST = 10'd240;

	typedef enum logic {
		REG_PANEL_W = 1'b0,
		REG_PANEL_H = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		HDR_CASET    = 4'd0,
		HDR_COL0_HI  = 4'd1,
		HDR_COL0_LO  = 4'd2,
		HDR_COL1_HI  = 4'd3,
		HDR_COL1_LO  = 4'd4,
		HDR_RASET    = 4'd5,
		HDR_ROW0_HI  = 4'd6,
		HDR_ROW0_LO  = 4'd7,
		HDR_ROW1_HI  = 4'd8,
		HDR_ROW1_LO  = 4'd9,
		HDR_RAMWR    = 4'd10
	} hdr_step_t;

	typedef enum logic [1:0] {
		SEL_HDR    = 2'd0,
		SEL_PIX_HI = 2'd1,
		SEL_PIX_LO = 2'd2
	} byte_sel_t;

	typedef struct packed {
		logic      load;
		logic      emit;
		byte_sel_t sel;
		hdr_step_t hdr;
		logic      count;
	} ctl_cmd_t;

	typedef struct packed {
		logic req_ok;
		logic empty;
		logic px_final;
	} ctl_sts_t;

endpackage

// ----- rtl/core/clipped_rect_fill_byte_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// clipped_rect_fill_byte_sequencer_unit
// Turns a clipped rectangle fill request into the serial byte stream of a
// display controller: column window, row window, memory write, pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries items with cmd. A start item
//   (cmd 0) loads a request while idle; off-panel requests are dropped, and
//   starts while busy are ignored. A pull item (cmd 1) while busy yields one
//   byte on the output channel (out_valid/out_ready) with is_data and last.
//   Pulls while idle give nothing. Starts give no output.
//   A pull's byte appears in out_byte in the cycle after it is accepted. A
//   new item is taken every cycle as long as the output register is empty
//   or is being drained that same cycle. When the receiver stalls, the byte
//   holds and in_ready drops until it is taken.
//   A fill run is 11 header bytes plus two bytes per pixel.
//   panel_width and panel_height sit at APB byte addresses 0 and 4; write
//   them only while the block is idle.
//   Reset clears the sequencer to idle, empties the output register and
//   sets the panel to 320 by 240.
// ----------------------------------------------------------------------------
module clipped_rect_fill_byte_sequencer_unit
	import crfbs_pkg::*;
#(
	parameter int DIM_BITS = 9
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]   prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                cmd,
	input  logic [COORD_W-1:0]  start_x,
	input  logic [COORD_W-1:0]  start_y,
	input  logic [COORD_W-1:0]  rect_width,
	input  logic [COORD_W-1:0]  rect_height,
	input  logic [WORD_W-1:0]   fill_color,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [BYTE_W-1:0]   out_byte,
	output logic                is_data,
	output logic                last
);

	logic [PANEL_W-1:0] panel_w;
	logic [PANEL_W-1:0] panel_h;
	ctl_cmd_t           ctl;
	ctl_sts_t           sts;

	crfbs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.panel_w (panel_w),
		.panel_h (panel_h)
	);

	crfbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	crfbs_dp #(
		.DIM_BITS (DIM_BITS)
	) u_dp (
		.clk         (clk),
		.panel_w     (panel_w),
		.panel_h     (panel_h),
		.start_x     (start_x),
		.start_y     (start_y),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.fill_color  (fill_color),
		.ctl         (ctl),
		.sts         (sts),
		.out_byte    (out_byte),
		.is_data     (is_data),
		.last        (last)
	);

endmodule

// ----- rtl/core/crfbs_regs.sv -----
// ----------------------------------------------------------------------------
// crfbs_regs
// APB register file holding the panel width and height used for clipping.
// ----------------------------------------------------------------------------
module crfbs_regs
	import crfbs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [APB_AW-1:0]    paddr,
	input  logic [APB_DW-1:0]    pwdata,
	output logic [APB_DW-1:0]    prdata,
	output logic                 pready,
	output logic [PANEL_W-1:0]   panel_w,
	output logic [PANEL_W-1:0]   panel_h
);

	logic [PANEL_W-1:0] panel_w_q;
	logic [PANEL_W-1:0] panel_h_q;
	reg_idx_t           idx;
	logic               wr_en;

	assign idx    = reg_idx_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_w_q <= PANEL_W_RST;
			panel_h_q <= PANEL_H_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_PANEL_W: panel_w_q <= pwdata[PANEL_W-1:0];
				REG_PANEL_H: panel_h_q <= pwdata[PANEL_W-1:0];
				default:     panel_w_q <= panel_w_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PANEL_W: prdata = {{(APB_DW-PANEL_W){1'b0}}, panel_w_q};
			REG_PANEL_H: prdata = {{(APB_DW-PANEL_W){1'b0}}, panel_h_q};
			default:     prdata = '0;
		endcase
	end

	assign panel_w = panel_w_q;
	assign panel_h = panel_h_q;

endmodule

// ----- rtl/core/crfbs_ctrl.sv -----
// ----------------------------------------------------------------------------
// crfbs_ctrl
// Sequencer state machine: walks the header steps and the pixel halves and
// owns both channel handshakes.
// ----------------------------------------------------------------------------
module crfbs_ctrl
	import crfbs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     cmd,
	output logic     out_valid,
	input  logic     out_ready,
	input  ctl_sts_t sts,
	output ctl_cmd_t ctl
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HEADER,
		ST_PIX_HI,
		ST_PIX_LO
	} state_t;

	state_t    state_q;
	hdr_step_t hdr_q;
	logic      out_valid_q;
	logic      accept;
	logic      pull;

	assign in_ready  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;
	assign pull      = accept && (cmd == CMD_PULL) && (state_q != ST_IDLE);

	always_comb begin
		ctl.load  = accept && (cmd == CMD_START) && (state_q == ST_IDLE) && sts.req_ok;
		ctl.emit  = pull;
		ctl.hdr   = hdr_q;
		ctl.count = pull && (state_q == ST_PIX_LO) && !sts.px_final;
		unique case (state_q)
			ST_PIX_HI: ctl.sel = SEL_PIX_HI;
			ST_PIX_LO: ctl.sel = SEL_PIX_LO;
			default:   ctl.sel = SEL_HDR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hdr_q       <= HDR_CASET;
			out_valid_q <= 1'b0;
		end else begin
			if (pull) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (ctl.load) begin
				state_q <= ST_HEADER;
				hdr_q   <= HDR_CASET;
			end else if (pull) begin
				unique case (state_q)
					ST_HEADER: begin
						if (hdr_q == HDR_RAMWR) begin
							hdr_q   <= HDR_CASET;
							state_q <= sts.empty ? ST_IDLE : ST_PIX_HI;
						end else begin
							hdr_q <= hdr_step_t'(hdr_q + 4'd1);
						end
					end
					ST_PIX_HI: state_q <= ST_PIX_LO;
					ST_PIX_LO: state_q <= sts.px_final ? ST_IDLE : ST_PIX_HI;
					default:   state_q <= ST_IDLE;
				endcase
			end
		end
	end

endmodule

// ----- rtl/core/crfbs_dp.sv -----
// ----------------------------------------------------------------------------
// crfbs_dp
// Datapath: clips the request, holds the address window, pixel value and
// pixel counters, and registers the outgoing byte.
// ----------------------------------------------------------------------------
module crfbs_dp
	import crfbs_pkg::*;
#(
	parameter int DIM_BITS = 9
) (
	input  logic                clk,
	input  logic [PANEL_W-1:0]  panel_w,
	input  logic [PANEL_W-1:0]  panel_h,
	input  logic [COORD_W-1:0]  start_x,
	input  logic [COORD_W-1:0]  start_y,
	input  logic [COORD_W-1:0]  rect_width,
	input  logic [COORD_W-1:0]  rect_height,
	input  logic [WORD_W-1:0]   fill_color,
	input  ctl_cmd_t            ctl,
	output ctl_sts_t            sts,
	output logic [BYTE_W-1:0]   out_byte,
	output logic                is_data,
	output logic                last
);

	logic [WORD_W-1:0]   col_first_q;
	logic [WORD_W-1:0]   col_final_q;
	logic [WORD_W-1:0]   row_first_q;
	logic [WORD_W-1:0]   row_final_q;
	logic [WORD_W-1:0]   pixel_q;
	logic [DIM_BITS-1:0] cols_q;
	logic [DIM_BITS-1:0] rows_q;
	logic [BYTE_W-1:0]   byte_q;
	logic                data_q;
	logic                last_q;

	logic [PANEL_W:0]    x_end;
	logic [PANEL_W:0]    y_end;
	logic [COORD_W-1:0]  w_c;
	logic [COORD_W-1:0]  h_c;
	logic [PANEL_W-1:0]  w_room;
	logic [PANEL_W-1:0]  h_room;
	logic [WORD_W-1:0]   span;
	logic [BYTE_W-1:0]   byte_d;
	logic                data_d;
	logic                last_d;

	assign x_end  = {2'b00, start_x} + {2'b00, rect_width};
	assign y_end  = {2'b00, start_y} + {2'b00, rect_height};
	assign w_room = panel_w - {1'b0, start_x};
	assign h_room = panel_h - {1'b0, start_y};

	always_comb begin
		w_c = rect_width;
		if ((rect_width != '0) && (x_end > {1'b0, panel_w})) begin
			w_c = w_room[COORD_W-1:0];
		end
		h_c = rect_height;
		if ((rect_height != '0) && (y_end > {1'b0, panel_h})) begin
			h_c = h_room[COORD_W-1:0];
		end
	end

	assign sts.req_ok   = ({1'b0, start_x} < panel_w) && ({1'b0, start_y} < panel_h);
	assign sts.empty    = (cols_q == '0) || (rows_q == '0);
	assign sts.px_final = (cols_q <= DIM_BITS'(1)) && (rows_q <= DIM_BITS'(1));

	assign span = col_final_q - col_first_q + 16'd1;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			col_first_q <= WORD_W'(start_x);
			col_final_q <= WORD_W'(start_x) + WORD_W'(w_c) - 16'd1;
			row_first_q <= WORD_W'(start_y);
			row_final_q <= WORD_W'(start_y) + WORD_W'(h_c) - 16'd1;
			pixel_q     <= fill_color;
			cols_q      <= DIM_BITS'(w_c);
			rows_q      <= DIM_BITS'(h_c);
		end else if (ctl.count) begin
			if (cols_q > DIM_BITS'(1)) begin
				cols_q <= cols_q - DIM_BITS'(1);
			end else begin
				rows_q <= rows_q - DIM_BITS'(1);
				cols_q <= span[DIM_BITS-1:0];
			end
		end
	end

	always_comb begin
		byte_d = pixel_q[WORD_W-1:BYTE_W];
		data_d = 1'b1;
		last_d = 1'b0;
		unique case (ctl.sel)
			SEL_HDR: begin
				unique case (ctl.hdr)
					HDR_CASET:   begin byte_d = OP_CASET; data_d = 1'b0; end
					HDR_COL0_HI: byte_d = col_first_q[WORD_W-1:BYTE_W];
					HDR_COL0_LO: byte_d = col_first_q[BYTE_W-1:0];
					HDR_COL1_HI: byte_d = col_final_q[WORD_W-1:BYTE_W];
					HDR_COL1_LO: byte_d = col_final_q[BYTE_W-1:0];
					HDR_RASET:   begin byte_d = OP_RASET; data_d = 1'b0; end
					HDR_ROW0_HI: byte_d = row_first_q[WORD_W-1:BYTE_W];
					HDR_ROW0_LO: byte_d = row_first_q[BYTE_W-1:0];
					HDR_ROW1_HI: byte_d = row_final_q[WORD_W-1:BYTE_W];
					HDR_ROW1_LO: byte_d = row_final_q[BYTE_W-1:0];
					HDR_RAMWR: begin
						byte_d = OP_RAMWR;
						data_d = 1'b0;
						last_d = sts.empty;
					end
					default:     byte_d = OP_RAMWR;
				endcase
			end
			SEL_PIX_HI: byte_d = pixel_q[WORD_W-1:BYTE_W];
			SEL_PIX_LO: begin
				byte_d = pixel_q[BYTE_W-1:0];
				last_d = sts.px_final;
			end
			default:    byte_d = pixel_q[WORD_W-1:BYTE_W];
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			byte_q <= byte_d;
			data_q <= data_d;
			last_q <= last_d;
		end
	end

	assign out_byte = byte_q;
	assign is_data  = data_q;
	assign last     = last_q;

endmodule

// ----- bench/crfbs_stream_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crfbs_stream_checker
// Watches the register port and both item channels of the fill sequencer,
// keeps its own copy of the panel size and the fill run state, and works out
// the display byte that each accepted pull must give. Every byte taken from
// the output is compared field by field with the oldest byte still owed.
// Reports the mismatch count, the bytes still owed and the pulls the current
// run still needs.
// ----------------------------------------------------------------------------
module crfbs_stream_checker
	import crfbs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [APB_AW-1:0]  paddr,
	input  logic [APB_DW-1:0]  pwdata,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               cmd,
	input  logic [COORD_W-1:0] start_x,
	input  logic [COORD_W-1:0] start_y,
	input  logic [COORD_W-1:0] rect_width,
	input  logic [COORD_W-1:0] rect_height,
	input  logic [WORD_W-1:0]  fill_color,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [BYTE_W-1:0]  out_byte,
	input  logic               is_data,
	input  logic               last,
	output int                 mismatches,
	output int                 bytes_waiting,
	output int                 pulls_owed
);

	localparam int HEADER_BYTES = 11;

	typedef struct packed {
		logic [BYTE_W-1:0] value;
		logic              is_data;
		logic              last;
	} disp_byte_t;

	disp_byte_t         owed_bytes[$];
	logic [PANEL_W-1:0] panel_w;
	logic [PANEL_W-1:0] panel_h;
	logic               run_busy;
	logic               in_pixels;
	logic               low_half;
	hdr_step_t          hdr_pos;
	logic [WORD_W-1:0]  col_first;
	logic [WORD_W-1:0]  col_final;
	logic [WORD_W-1:0]  row_first;
	logic [WORD_W-1:0]  row_final;
	logic [WORD_W-1:0]  color;
	logic [COORD_W-1:0] cols_left;
	logic [COORD_W-1:0] rows_left;
	int                 run_pulls;

	always @(posedge clk or negedge arst_n) begin
		disp_byte_t got;
		disp_byte_t want;
		disp_byte_t nb;
		int         x;
		int         y;
		int         w;
		int         h;
		int         errs;
		if (!arst_n) begin
			owed_bytes.delete();
			panel_w = PANEL_W_RST;
			panel_h = PANEL_H_RST;
			run_busy = 1'b0;
			in_pixels = 1'b0;
			low_half = 1'b0;
			hdr_pos = HDR_CASET;
			col_first = '0;
			col_final = '0;
			row_first = '0;
			row_final = '0;
			color = '0;
			cols_left = '0;
			rows_left = '0;
			run_pulls = 0;
			mismatches <= 0;
			bytes_waiting <= 0;
			pulls_owed <= 0;
		end else begin
			errs = 0;
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[2]))
					REG_PANEL_W: panel_w = pwdata[PANEL_W-1:0];
					REG_PANEL_H: panel_h = pwdata[PANEL_W-1:0];
				endcase
			end

			if (out_valid && out_ready) begin
				got = {out_byte, is_data, last};
				if (owed_bytes.size() == 0) begin
					errs++;
					$display("%0t: unexpected byte: expected none, got %h/%b/%b",
						$time, got.value, got.is_data, got.last);
				end else begin
					want = owed_bytes.pop_front();
					if (got.value !== want.value) begin
						errs++;
						$display("%0t: out_byte expected %h got %h",
							$time, want.value, got.value);
					end
					if (got.is_data !== want.is_data) begin
						errs++;
						$display("%0t: is_data expected %b got %b",
							$time, want.is_data, got.is_data);
					end
					if (got.last !== want.last) begin
						errs++;
						$display("%0t: last expected %b got %b",
							$time, want.last, got.last);
					end
				end
			end

			if (in_valid && in_ready) begin
				if (cmd == CMD_START) begin
					x = int'(start_x);
					y = int'(start_y);
					w = int'(rect_width);
					h = int'(rect_height);
					if (!run_busy && x < int'(panel_w) && y < int'(panel_h)) begin
						if (w != 0 && x + w - 1 >= int'(panel_w))
							w = int'(panel_w) - x;
						if (h != 0 && y + h - 1 >= int'(panel_h))
							h = int'(panel_h) - y;
						col_first = WORD_W'(x);
						col_final = WORD_W'(x + w - 1);
						row_first = WORD_W'(y);
						row_final = WORD_W'(y + h - 1);
						color = fill_color;
						cols_left = COORD_W'(w);
						rows_left = COORD_W'(h);
						low_half = 1'b0;
						in_pixels = 1'b0;
						hdr_pos = HDR_CASET;
						run_busy = 1'b1;
						run_pulls = HEADER_BYTES + 2 * w * h;
					end
				end else if (run_busy) begin
					run_pulls--;
					nb.is_data = 1'b1;
					nb.last = 1'b0;
					if (!in_pixels) begin
						case (hdr_pos)
							HDR_CASET: begin
								nb.value = OP_CASET;
								nb.is_data = 1'b0;
							end
							HDR_COL0_HI: nb.value = col_first[15:8];
							HDR_COL0_LO: nb.value = col_first[7:0];
							HDR_COL1_HI: nb.value = col_final[15:8];
							HDR_COL1_LO: nb.value = col_final[7:0];
							HDR_RASET: begin
								nb.value = OP_RASET;
								nb.is_data = 1'b0;
							end
							HDR_ROW0_HI: nb.value = row_first[15:8];
							HDR_ROW0_LO: nb.value = row_first[7:0];
							HDR_ROW1_HI: nb.value = row_final[15:8];
							HDR_ROW1_LO: nb.value = row_final[7:0];
							default: begin
								nb.value = OP_RAMWR;
								nb.is_data = 1'b0;
								nb.last = (cols_left == 0) || (rows_left == 0);
								if (nb.last)
									run_busy = 1'b0;
								else
									in_pixels = 1'b1;
							end
						endcase
						if (hdr_pos != HDR_RAMWR)
							hdr_pos = hdr_step_t'(hdr_pos + 4'd1);
					end else if (!low_half) begin
						nb.value = color[15:8];
						low_half = 1'b1;
					end else begin
						nb.value = color[7:0];
						low_half = 1'b0;
						nb.last = (cols_left <= 1) && (rows_left <= 1);
						if (nb.last) begin
							run_busy = 1'b0;
						end else if (cols_left > 1) begin
							cols_left--;
						end else begin
							rows_left--;
							cols_left = COORD_W'(col_final - col_first + 1);
						end
					end
					owed_bytes.push_back(nb);
				end
			end

			mismatches <= mismatches + errs;
			bytes_waiting <= owed_bytes.size();
			pulls_owed <= run_pulls;
		end
	end

endmodule

// ----- bench/tb_clipped_rect_fill_byte_sequencer_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_clipped_rect_fill_byte_sequencer_unit
// Drives fill requests and byte pulls into the sequencer under several panel
// sizes and idle patterns: a short directed opening (idle pull, corner clip
// with starts while busy under a long output hold-off, header-only run with
// wrapped end column, off-panel drops), then random phases of complete fill
// runs mixed with stray items. The checker beside the block scores bytes.
// ----------------------------------------------------------------------------
module tb_clipped_rect_fill_byte_sequencer_unit;
	import crfbs_pkg::*;

	localparam int HOLD_CYCLES = 300;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [APB_AW-1:0]  paddr;
	logic [APB_DW-1:0]  pwdata;
	logic [APB_DW-1:0]  prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic               cmd;
	logic [COORD_W-1:0] start_x;
	logic [COORD_W-1:0] start_y;
	logic [COORD_W-1:0] rect_width;
	logic [COORD_W-1:0] rect_height;
	logic [WORD_W-1:0]  fill_color;
	logic               out_valid;
	logic               out_ready;
	logic [BYTE_W-1:0]  out_byte;
	logic               is_data;
	logic               last;

	int mismatches;
	int bytes_waiting;
	int pulls_owed;

	int idle_pct = 0;
	int stall_pct = 0;
	int items_sent = 0;
	int cur_pw = 320;
	int cur_ph = 240;
	bit hold_request = 1'b0;

	int phase_pw[6]    = '{320, 1, 512, 0, 0, 1023};
	int phase_ph[6]    = '{240, 1, 512, 0, 512, 3};
	int phase_idle[6]  = '{0, 88, 0, 37, 0, 37};
	int phase_stall[6] = '{0, 0, 88, 37, 0, 37};
	int phase_items[6] = '{200, 200, 220, 220, 40, 180};

	clipped_rect_fill_byte_sequencer_unit dut (.*);

	crfbs_stream_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("tb_clipped_rect_fill_byte_sequencer_unit: errors");
		$finish;
	end

	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic send_item(input logic c, input int x, input int y, input int w,
		input int h, input int color, output int due);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		start_x <= COORD_W'(x);
		start_y <= COORD_W'(y);
		rect_width <= COORD_W'(w);
		rect_height <= COORD_W'(h);
		fill_color <= WORD_W'(color);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		due = pulls_owed;
		items_sent++;
	endtask

	// start, then pull until the run is drained; stray starts land while busy
	task automatic fill_run(input int x, input int y, input int w, input int h,
		input int color, input int busy_start_pct);
		int left;
		int ignored;
		send_item(CMD_START, x, y, w, h, color, ignored);
		send_item(CMD_PULL, $urandom, $urandom, $urandom, $urandom, $urandom, left);
		left--;
		while (left > 0) begin
			if ($urandom_range(99) < busy_start_pct)
				send_item(CMD_START, $urandom, $urandom, $urandom, $urandom, $urandom,
					ignored);
			send_item(CMD_PULL, $urandom, $urandom, $urandom, $urandom, $urandom,
				ignored);
			left--;
		end
	endtask

	task automatic apb_write(input reg_idx_t idx, input int value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic reconfigure(input int pw, input int ph);
		in_valid <= 1'b0;
		@(posedge clk);
		while (bytes_waiting != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		apb_write(REG_PANEL_W, pw);
		apb_write(REG_PANEL_H, ph);
		cur_pw = pw;
		cur_ph = ph;
	endtask

	initial begin
		int x;
		int y;
		int w;
		int h;
		int span_x;
		int span_y;
		int shape;
		int quota;
		int ignored;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		cmd <= CMD_PULL;
		start_x <= '0;
		start_y <= '0;
		rect_width <= '0;
		rect_height <= '0;
		fill_color <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(CMD_PULL, 0, 0, 0, 0, 0, ignored);
		hold_request = 1'b1;
		fill_run(319, 239, 511, 511, 'hffff, 20);
		fill_run(0, 0, 0, 5, 0, 0);
		send_item(CMD_START, 320, 0, 1, 1, 'h1234, ignored);
		send_item(CMD_START, 0, 240, 1, 1, 'h5678, ignored);

		for (int p = 0; p < 6; p++) begin
			if (p == 3)
				reconfigure($urandom_range(1, 64), $urandom_range(1, 64));
			else
				reconfigure(phase_pw[p], phase_ph[p]);
			idle_pct = phase_idle[p];
			stall_pct = phase_stall[p];
			quota = items_sent + phase_items[p];
			while (items_sent < quota) begin
				if ($urandom_range(99) < 80) begin
					span_x = (cur_pw > 512) ? 512 : cur_pw;
					span_y = (cur_ph > 512) ? 512 : cur_ph;
					x = (span_x == 0 || $urandom_range(99) < 10) ?
						$urandom_range(0, 511) : $urandom_range(0, span_x - 1);
					y = (span_y == 0 || $urandom_range(99) < 10) ?
						$urandom_range(0, 511) : $urandom_range(0, span_y - 1);
					w = $urandom_range(0, 3);
					h = $urandom_range(0, 3);
					shape = $urandom_range(99);
					if (shape < 6) begin
						w = $urandom_range(256, 511);
						h = $urandom_range(0, 2);
						if (span_x > 0 && cur_pw <= 512)
							x = cur_pw - 1 - $urandom_range(0, (span_x > 3) ? 2 : span_x - 1);
					end else if (shape < 12) begin
						h = $urandom_range(256, 511);
						w = $urandom_range(0, 2);
						if (span_y > 0 && cur_ph <= 512)
							y = cur_ph - 1 - $urandom_range(0, (span_y > 3) ? 2 : span_y - 1);
					end else if (shape < 20) begin
						w = $urandom_range(4, 12);
						h = $urandom_range(1, 4);
					end
					fill_run(x, y, w, h, $urandom, 4);
				end else if ($urandom_range(1) == 0 || cur_pw > 511) begin
					send_item(CMD_PULL, $urandom, $urandom, $urandom, $urandom, $urandom,
						ignored);
				end else begin
					send_item(CMD_START, $urandom_range(cur_pw, 511), $urandom, $urandom,
						$urandom, $urandom, ignored);
				end
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (bytes_waiting != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("tb_clipped_rect_fill_byte_sequencer_unit: clean");
		else
			$display("tb_clipped_rect_fill_byte_sequencer_unit: errors");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/crfbs_pkg.sv
rtl/core/crfbs_regs.sv
rtl/core/crfbs_ctrl.sv
rtl/core/crfbs_dp.sv
rtl/core/clipped_rect_fill_byte_sequencer_unit.sv
bench/crfbs_stream_checker.sv
bench/tb_clipped_rect_fill_byte_sequencer_unit.sv
